/* rtl/sbc_pkg.sv */
// ----------------------------------------------------------------------------
// sbc_pkg
// Shared widths, constants, codes and control structs of the save layout
// block counter.
// ----------------------------------------------------------------------------
package sbc_pkg;

  localparam int FLEN_W      = 22;
  localparam int TOTAL_W     = 21;
  localparam int SECT_W      = 17;
  localparam int HDR_W       = 16;
  localparam int POS_W       = 4;
  localparam int DVD_W       = 23;
  localparam int CNT_W       = 5;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 17;

  localparam int MAX_FILES   = 8;

  localparam logic [SECT_W-1:0]  SECTOR_HDR   = SECT_W'(32);
  localparam logic [SECT_W-1:0]  SECT_MIN     = SECT_W'(64);
  localparam logic [SECT_W-1:0]  SECT_MAX     = SECT_W'(65536);
  localparam logic [SECT_W-1:0]  SECT_RESET   = SECT_W'(8192);
  localparam logic [DVD_W-1:0]   HDR_EXTRA    = DVD_W'(48);
  localparam logic [TOTAL_W-1:0] TOTAL_MAX    = {TOTAL_W{1'b1}};
  localparam logic [POS_W-1:0]   POS_MAX      = {POS_W{1'b1}};
  localparam logic [POS_W-1:0]   POS_LIMIT    = POS_W'(MAX_FILES);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SECT_LEN    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_HEADER_SIZE = CFG_IDX_W'(1);

  // divider dividend sources
  localparam logic [1:0] DIV_SRC_HDR   = 2'd0;
  localparam logic [1:0] DIV_SRC_FIRST = 2'd1;
  localparam logic [1:0] DIV_SRC_LATER = 2'd2;

  // what gets added to the running total
  localparam logic [1:0] ADD_ONE   = 2'd0;
  localparam logic [1:0] ADD_QUOT  = 2'd1;
  localparam logic [1:0] ADD_QUOT1 = 2'd2;

  typedef struct packed {
    logic       load_item;
    logic       start_div;
    logic [1:0] div_src;
    logic       accum;
    logic [1:0] add_sel;
    logic       mark_ovf;
    logic       step_pos;
    logic       emit;
  } sbc_cmd_t;

  typedef struct packed {
    logic pos_full;
    logic pos_zero;
    logic div_done;
    logic fits;
    logic last;
  } sbc_sts_t;

endpackage

/* rtl/sbc_in_if.sv */
// ----------------------------------------------------------------------------
// sbc_in_if
// Input channel: one file length word per handshake.
// ----------------------------------------------------------------------------
interface sbc_in_if;
  logic                       valid;
  logic                       ready;
  logic [sbc_pkg::FLEN_W-1:0] flen;
  logic                       last_file;

  modport source (output valid, output flen, output last_file, input ready);
  modport sink   (input valid, input flen, input last_file, output ready);
endinterface

/* rtl/sbc_out_if.sv */
// ----------------------------------------------------------------------------
// sbc_out_if
// Result channel: one sector total word per completed save.
// ----------------------------------------------------------------------------
interface sbc_out_if;
  logic                        valid;
  logic                        ready;
  logic [sbc_pkg::TOTAL_W-1:0] total_blocks;
  logic                        too_many_files;

  modport source (output valid, output total_blocks, output too_many_files, input ready);
  modport sink   (input valid, input total_blocks, input too_many_files, output ready);
endinterface

/* rtl/sbc_div.sv */
// ----------------------------------------------------------------------------
// sbc_div
// Restoring divider, one quotient bit per cycle. Quotient and remainder hold
// until the next start.
// ----------------------------------------------------------------------------
module sbc_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [sbc_pkg::DVD_W-1:0]    dividend,
  input  logic [sbc_pkg::SECT_W-1:0]   divisor,
  output logic                         done,
  output logic [sbc_pkg::DVD_W-1:0]    quot,
  output logic [sbc_pkg::SECT_W-1:0]   rem
);

  logic [sbc_pkg::DVD_W-1:0]  dvd_r, dvd_nxt;
  logic [sbc_pkg::SECT_W-1:0] dvs_r, dvs_nxt;
  logic [sbc_pkg::SECT_W-1:0] rem_r, rem_nxt;
  logic [sbc_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;
  logic                       busy_r, busy_nxt;
  logic                       done_r, done_nxt;
  logic [sbc_pkg::SECT_W:0]   rem_sh;
  logic [sbc_pkg::SECT_W:0]   rem_diff;
  logic                       q_bit;

  always_comb begin
    rem_sh   = {rem_r, dvd_r[sbc_pkg::DVD_W-1]};
    rem_diff = rem_sh - {1'b0, dvs_r};
    q_bit    = (rem_sh >= {1'b0, dvs_r});
    dvd_nxt  = dvd_r;
    dvs_nxt  = dvs_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      dvd_nxt  = dividend;
      dvs_nxt  = divisor;
      rem_nxt  = '0;
      cnt_nxt  = sbc_pkg::CNT_W'(sbc_pkg::DVD_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // quotient bits shift in where dividend bits leave
      dvd_nxt = {dvd_r[sbc_pkg::DVD_W-2:0], q_bit};
      rem_nxt = q_bit ? rem_diff[sbc_pkg::SECT_W-1:0] : rem_sh[sbc_pkg::SECT_W-1:0];
      cnt_nxt = cnt_r - sbc_pkg::CNT_W'(1);
      if (cnt_r == sbc_pkg::CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    dvs_r <= dvs_nxt;
    rem_r <= rem_nxt;
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign done = done_r;
  assign quot = dvd_r;
  assign rem  = rem_r;

endmodule

/* rtl/sbc_dp.sv */
// ----------------------------------------------------------------------------
// sbc_dp
// Datapath: configuration registers, item latch, divider operand selection,
// running total, file position, overflow flag and result register.
// ----------------------------------------------------------------------------
module sbc_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [sbc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [sbc_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  logic [sbc_pkg::FLEN_W-1:0]        in_flen,
  input  logic                              in_last_file,
  input  sbc_pkg::sbc_cmd_t                 cmd,
  output sbc_pkg::sbc_sts_t                 sts,
  output logic [sbc_pkg::TOTAL_W-1:0]       out_total_blocks,
  output logic                              out_too_many_files
);

  logic [sbc_pkg::SECT_W-1:0]      sect_len_r;
  logic [sbc_pkg::HDR_W-1:0]       header_size_r;
  logic [sbc_pkg::FLEN_W-1:0]      size_r;
  logic                            last_r;
  logic [sbc_pkg::TOTAL_W-1:0]     total_r, total_nxt;
  logic [sbc_pkg::POS_W-1:0]       pos_r, pos_nxt;
  logic                            ovf_r, ovf_nxt;
  logic [sbc_pkg::TOTAL_W-1:0]     res_total_r;
  logic                            res_ovf_r;

  logic [sbc_pkg::SECT_W-1:0]      ss;
  logic [sbc_pkg::SECT_W-1:0]      usable;
  logic [sbc_pkg::SECT_W:0]        space;
  logic [sbc_pkg::DVD_W:0]         excess;
  logic [sbc_pkg::DVD_W-1:0]       dividend;
  logic [sbc_pkg::DVD_W-1:0]       round_up;
  logic                            div_done;
  logic [sbc_pkg::DVD_W-1:0]       quot;
  logic [sbc_pkg::SECT_W-1:0]      rem;
  logic [sbc_pkg::DVD_W:0]         addend;
  logic [sbc_pkg::DVD_W:0]         sum;

  function automatic logic [sbc_pkg::SECT_W-1:0] usable_or_ss(
    input logic [1:0]                 src,
    input logic [sbc_pkg::SECT_W-1:0] s,
    input logic [sbc_pkg::SECT_W-1:0] u
  );
    usable_or_ss = (src == sbc_pkg::DIV_SRC_HDR) ? s : u;
  endfunction

  always_comb begin
    if (sect_len_r < sbc_pkg::SECT_MIN) begin
      ss = sbc_pkg::SECT_MIN;
    end else if (sect_len_r > sbc_pkg::SECT_MAX) begin
      ss = sbc_pkg::SECT_MAX;
    end else begin
      ss = sect_len_r;
    end
    usable   = ss - sbc_pkg::SECTOR_HDR;
    round_up = sbc_pkg::DVD_W'(usable) - sbc_pkg::DVD_W'(1);
    // room left in the first sector after the header region, may go negative
    space    = {1'b0, usable} - {1'b0, rem};
    excess   = {2'b00, size_r} - {{(sbc_pkg::DVD_W-sbc_pkg::SECT_W){space[sbc_pkg::SECT_W]}},
                                  space};
    case (cmd.div_src)
      sbc_pkg::DIV_SRC_HDR:   dividend = sbc_pkg::DVD_W'(header_size_r) + sbc_pkg::HDR_EXTRA;
      sbc_pkg::DIV_SRC_FIRST: dividend = excess[sbc_pkg::DVD_W-1:0] + round_up;
      sbc_pkg::DIV_SRC_LATER: dividend = sbc_pkg::DVD_W'(size_r) + round_up;
      default:                dividend = '0;
    endcase
    case (cmd.add_sel)
      sbc_pkg::ADD_ONE:   addend = (sbc_pkg::DVD_W+1)'(1);
      sbc_pkg::ADD_QUOT:  addend = {1'b0, quot};
      sbc_pkg::ADD_QUOT1: addend = {1'b0, quot} + (sbc_pkg::DVD_W+1)'(1);
      default:            addend = '0;
    endcase
    sum = (sbc_pkg::DVD_W+1)'(total_r) + addend;
  end

  sbc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.start_div),
    .dividend (dividend),
    .divisor  (usable_or_ss(cmd.div_src, ss, usable)),
    .done     (div_done),
    .quot     (quot),
    .rem      (rem)
  );

  always_comb begin
    total_nxt = total_r;
    pos_nxt   = pos_r;
    ovf_nxt   = ovf_r;
    if (cmd.accum) begin
      total_nxt = (sum > (sbc_pkg::DVD_W+1)'(sbc_pkg::TOTAL_MAX)) ?
                  sbc_pkg::TOTAL_MAX : sum[sbc_pkg::TOTAL_W-1:0];
    end
    if (cmd.mark_ovf) begin
      ovf_nxt = 1'b1;
    end
    if (cmd.step_pos && (pos_r != sbc_pkg::POS_MAX)) begin
      pos_nxt = pos_r + sbc_pkg::POS_W'(1);
    end
    if (cmd.emit) begin
      total_nxt = '0;
      pos_nxt   = '0;
      ovf_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      size_r <= in_flen;
      last_r <= in_last_file;
    end
    if (cmd.emit) begin
      res_total_r <= ovf_r ? '0 : total_r;
      res_ovf_r   <= ovf_r;
    end
    if (!rst_n) begin
      sect_len_r    <= sbc_pkg::SECT_RESET;
      header_size_r <= '0;
      total_r       <= '0;
      pos_r         <= '0;
      ovf_r         <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          sbc_pkg::REG_SECT_LEN:    sect_len_r    <= cfg_wdata;
          sbc_pkg::REG_HEADER_SIZE: header_size_r <= cfg_wdata[sbc_pkg::HDR_W-1:0];
          default: ;
        endcase
      end
      total_r <= total_nxt;
      pos_r   <= pos_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  assign sts.pos_full = (pos_r >= sbc_pkg::POS_LIMIT);
  assign sts.pos_zero = (pos_r == '0);
  assign sts.div_done = div_done;
  assign sts.fits     = (size_r == '0) || excess[sbc_pkg::DVD_W] || (excess == '0);
  assign sts.last     = last_r;

  assign out_total_blocks   = res_total_r;
  assign out_too_many_files = res_ovf_r;

endmodule

/* rtl/sbc_ctrl.sv */
// ----------------------------------------------------------------------------
// sbc_ctrl
// Controller: sequences one file word through header remainder, sector
// division and accumulation, and owns the result valid flag.
// ----------------------------------------------------------------------------
module sbc_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  sbc_pkg::sbc_sts_t  sts,
  output sbc_pkg::sbc_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_LAUNCH = 3'd1;
  localparam logic [2:0] S_MOD    = 3'd2;
  localparam logic [2:0] S_DIV    = 3'd3;
  localparam logic [2:0] S_FIN    = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_nxt     = S_LAUNCH;
        end
      end
      S_LAUNCH: begin
        if (sts.pos_full) begin
          cmd.mark_ovf = 1'b1;
          state_nxt    = S_FIN;
        end else if (sts.pos_zero) begin
          cmd.start_div = 1'b1;
          cmd.div_src   = sbc_pkg::DIV_SRC_HDR;
          state_nxt     = S_MOD;
        end else begin
          cmd.start_div = 1'b1;
          cmd.div_src   = sbc_pkg::DIV_SRC_LATER;
          state_nxt     = S_DIV;
        end
      end
      S_MOD: begin
        if (sts.div_done) begin
          if (sts.fits) begin
            cmd.accum   = 1'b1;
            cmd.add_sel = sbc_pkg::ADD_ONE;
            state_nxt   = S_FIN;
          end else begin
            cmd.start_div = 1'b1;
            cmd.div_src   = sbc_pkg::DIV_SRC_FIRST;
            state_nxt     = S_DIV;
          end
        end
      end
      S_DIV: begin
        if (sts.div_done) begin
          cmd.accum   = 1'b1;
          // first file pays one extra sector for the shared one
          cmd.add_sel = sts.pos_zero ? sbc_pkg::ADD_QUOT1 : sbc_pkg::ADD_QUOT;
          state_nxt   = S_FIN;
        end
      end
      S_FIN: begin
        if (!sts.last) begin
          cmd.step_pos = 1'b1;
          state_nxt    = S_IDLE;
        end else if (out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  // a waiting result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_valid_r || out_ready))
    else $error("result overwritten while stalled");

  // every accepted word goes through the launch step
  a_accept_launch: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_LAUNCH))
    else $error("accepted word skipped launch");

  // divider only started from the launch or remainder step
  a_start_src: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start_div |-> (state_r == S_LAUNCH || state_r == S_MOD))
    else $error("divider started from wrong state");

  // files beyond the limit never reach the divider
  a_ovf_no_div: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LAUNCH && sts.pos_full) |-> (!cmd.start_div && cmd.mark_ovf))
    else $error("overflow file was counted");

  // an emit always leaves a valid result behind
  a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> out_valid_r)
    else $error("emitted result not valid");

endmodule

/* rtl/save_layout_block_counter.sv */
// ----------------------------------------------------------------------------
// save_layout_block_counter
// Counts storage sectors needed by a save made of up to eight sub-files.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one word per sub-file: flen and last_file. When the
//   word marked last_file has been processed, one word appears on out_ch with
//   total_blocks (0 on overflow) and too_many_files.
//   cfg_we/cfg_index/cfg_wdata write the sector length (index 0) and
//   header_size (index 1); write them only while the block is idle.
// Timing:
//   One word at a time. A later file runs from acceptance to ready again
//   through the launch step, the one-bit-per-cycle divider, the accumulate
//   step and the finish step. The first file of a save runs the divider
//   twice (header remainder, then sector count), or once when it fits in
//   the shared sector. Files past the limit skip the divider.
//   A result is visible in the cycle after the finish step.
// Reset:
//   rst_n (synchronous) clears the running save, the result flag and loads
//   sector length 8192, header_size 0.
// Stall:
//   A result waits in its output register; the next save keeps going and
//   only its last word holds in the finish step until the register is free.
// ----------------------------------------------------------------------------
module save_layout_block_counter (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [sbc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sbc_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  sbc_in_if.sink                          in_ch,
  sbc_out_if.source                       out_ch
);

  sbc_pkg::sbc_cmd_t cmd;
  sbc_pkg::sbc_sts_t sts;

  sbc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  sbc_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_flen            (in_ch.flen),
    .in_last_file       (in_ch.last_file),
    .cmd                (cmd),
    .sts                (sts),
    .out_total_blocks   (out_ch.total_blocks),
    .out_too_many_files (out_ch.too_many_files)
  );

endmodule
